@@ rtl/core/rbsi_pkg.sv @@
`default_nettype none
package rbsi_pkg;

  // Default geometry of the fixed point coordinates.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Number of spatial axes handled per test.
  localparam int NUM_AXES = 3;

  // Per-axis information that bypasses the dividers.
  typedef struct packed {
    logic [NUM_AXES-1:0] par;   // direction component is zero
    logic [NUM_AXES-1:0] pass;  // axis does not reject the ray on its own
  } rbsi_side_t;

endpackage
`default_nettype wire

@@ rtl/core/rbsi_div.sv @@
`default_nettype none
// Fully pipelined unsigned restoring divider: one quotient bit per stage.
// The dividend is num_mag shifted left by FB fraction bits; the sign travels alongside.
module rbsi_div #(
  parameter int CW = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FB = rbsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [CW:0]         num_mag,
  input  wire logic [CW-1:0]       den_mag,
  input  wire logic                neg_in,
  output      logic [CW+FB:0]      quot,
  output      logic                neg_out
);

  localparam int NW = CW + 1 + FB;

  // Per-stage registers; index k holds the state after k quotient bits.
  logic [CW-1:0] rem [1:NW];
  logic [NW-1:0] qt  [1:NW];
  logic [NW-1:0] dvd [1:NW];
  logic [CW-1:0] den [1:NW];
  logic          ng  [1:NW];

  genvar k;
  for (k = 0; k < NW; k++) begin : g_stage
    logic [CW-1:0] rem_in;
    logic [NW-1:0] qt_in;
    logic [NW-1:0] dvd_in;
    logic [CW-1:0] den_in;
    logic          ng_in;
    logic [CW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign qt_in  = '0;
      assign dvd_in = {num_mag, {FB{1'b0}}};
      assign den_in = den_mag;
      assign ng_in  = neg_in;
    end else begin : g_next
      assign rem_in = rem[k];
      assign qt_in  = qt[k];
      assign dvd_in = dvd[k];
      assign den_in = den[k];
      assign ng_in  = ng[k];
    end

    // Shift in the next dividend bit and try one subtraction.
    assign trial = {rem_in, dvd_in[NW-1-k]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? CW'(trial - {1'b0, den_in}) : trial[CW-1:0];
        qt[k+1]  <= {qt_in[NW-2:0], ge};
        dvd[k+1] <= dvd_in;
        den[k+1] <= den_in;
        ng[k+1]  <= ng_in;
      end
    end
  end

  assign quot    = qt[NW];
  assign neg_out = ng[NW];

endmodule
`default_nettype wire

@@ rtl/core/rbsi_isect.sv @@
`default_nettype none
// Saturates and orders the six slab parameters, then intersects the three
// axis intervals. Two register stages; the second is the output register.
module rbsi_isect #(
  parameter int CW = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FB = rbsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [CW+FB:0]         q_min [rbsi_pkg::NUM_AXES],
  input  wire logic                   n_min [rbsi_pkg::NUM_AXES],
  input  wire logic [CW+FB:0]         q_max [rbsi_pkg::NUM_AXES],
  input  wire logic                   n_max [rbsi_pkg::NUM_AXES],
  input  wire rbsi_pkg::rbsi_side_t   side,
  output      logic                   out_valid,
  output      logic                   hit,
  output      logic signed [CW-1:0]   distance
);

  localparam int NW = CW + 1 + FB;
  localparam logic [NW-1:0] POS_LIM = NW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [NW-1:0] NEG_MAG = NW'(64'd1 << (CW - 1));
  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  // Saturate a signed quotient to the coordinate range.
  function automatic logic signed [CW-1:0] sat(input logic [NW-1:0] q, input logic n);
    logic [NW-1:0] nq;
    nq = '0 - q;
    if (!n) begin
      sat = (q > POS_LIM) ? T_MAX : q[CW-1:0];
    end else begin
      sat = (q > NEG_MAG) ? T_MIN : nq[CW-1:0];
    end
  endfunction

  logic signed [CW-1:0] lo [rbsi_pkg::NUM_AXES];
  logic signed [CW-1:0] hi [rbsi_pkg::NUM_AXES];
  logic                 all_pass;
  logic                 v1;

  // First stage: per-axis interval, full range on a parallel axis.
  for (genvar a = 0; a < rbsi_pkg::NUM_AXES; a++) begin : g_axis
    logic signed [CW-1:0] ta;
    logic signed [CW-1:0] tb;
    assign ta = sat(q_min[a], n_min[a]);
    assign tb = sat(q_max[a], n_max[a]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (side.par[a]) begin
          lo[a] <= T_MIN;
          hi[a] <= T_MAX;
        end else if (ta > tb) begin
          lo[a] <= tb;
          hi[a] <= ta;
        end else begin
          lo[a] <= ta;
          hi[a] <= tb;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      all_pass <= &side.pass;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // Second stage: intersect X with Y, then with Z.
  logic signed [CW-1:0] tmin_xy;
  logic signed [CW-1:0] tmax_xy;
  logic signed [CW-1:0] tmin_xyz;
  logic                 miss_y;
  logic                 miss_z;

  always_comb begin
    miss_y   = (lo[0] > hi[1]) || (lo[1] > hi[0]);
    tmin_xy  = (lo[1] > lo[0]) ? lo[1] : lo[0];
    tmax_xy  = (hi[1] < hi[0]) ? hi[1] : hi[0];
    miss_z   = (tmin_xy > hi[2]) || (lo[2] > tmax_xy);
    tmin_xyz = (lo[2] > tmin_xy) ? lo[2] : tmin_xy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (all_pass && !miss_y && !miss_z) begin
        hit      <= 1'b1;
        distance <= tmin_xyz;
      end else begin
        hit      <= 1'b0;
        distance <= '0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ray_box_slab_intersect.sv @@
`default_nettype none
// Ray against axis-aligned box slab test. One test enters per clock and one
// result leaves per clock while m_axis_tready stays high; six bit-per-stage
// pipelined dividers form the slab parameters (Q16.16 at the default
// widths). The whole pipeline holds while a result waits on m_axis_tready.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF,
  localparam int IN_W  = ((12 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((COORD_WIDTH + 1 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output      logic             s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output      logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // hit, distance
  output      logic [OUT_W-1:0] m_axis_tdata
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = COORD_WIDTH + 1 + FRAC_BITS;
  localparam int NA = rbsi_pkg::NUM_AXES;

  logic en;
  logic out_valid;
  logic hit;
  logic signed [CW-1:0] distance;

  // The pipeline advances whenever the output register is free or being read.
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'({distance, hit});

  // Prepare stage: differences, magnitudes, signs and parallel checks.
  logic [CW:0]   nmin_mag [NA];
  logic [CW:0]   nmax_mag [NA];
  logic [CW-1:0] d_mag    [NA];
  logic          neg_min  [NA];
  logic          neg_max  [NA];
  rbsi_pkg::rbsi_side_t side0;
  logic          v0;

  for (genvar a = 0; a < NA; a++) begin : g_prep
    logic signed [CW-1:0] o;
    logic signed [CW-1:0] d;
    logic signed [CW-1:0] bmin;
    logic signed [CW-1:0] bmax;
    logic signed [CW:0]   dmin;
    logic signed [CW:0]   dmax;

    assign o    = s_axis_tdata[a*CW +: CW];
    assign d    = s_axis_tdata[(3+a)*CW +: CW];
    assign bmin = s_axis_tdata[(6+a)*CW +: CW];
    assign bmax = s_axis_tdata[(9+a)*CW +: CW];
    assign dmin = {bmin[CW-1], bmin} - {o[CW-1], o};
    assign dmax = {bmax[CW-1], bmax} - {o[CW-1], o};

    always_ff @(posedge clk) begin
      if (en) begin
        nmin_mag[a]   <= dmin[CW] ? (CW+1)'(-dmin) : dmin;
        nmax_mag[a]   <= dmax[CW] ? (CW+1)'(-dmax) : dmax;
        d_mag[a]      <= d[CW-1] ? CW'(-d) : d;
        neg_min[a]    <= dmin[CW] ^ d[CW-1];
        neg_max[a]    <= dmax[CW] ^ d[CW-1];
      end
    end
  end

  // Parallel flags for all axes: a parallel axis passes only with the origin inside.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        side0.par[a]  <= (s_axis_tdata[(3+a)*CW +: CW] == '0);
        side0.pass[a] <= (s_axis_tdata[(3+a)*CW +: CW] != '0) ||
                         (($signed(s_axis_tdata[(6+a)*CW +: CW]) <=
                           $signed(s_axis_tdata[a*CW +: CW])) &&
                          ($signed(s_axis_tdata[a*CW +: CW]) <=
                           $signed(s_axis_tdata[(9+a)*CW +: CW])));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
    end
  end

  // Six dividers, one per slab parameter.
  logic [NW-1:0] q_min [NA];
  logic [NW-1:0] q_max [NA];
  logic          n_min [NA];
  logic          n_max [NA];

  for (genvar a = 0; a < NA; a++) begin : g_div
    rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_div_min (
      .clk     (clk),
      .en      (en),
      .num_mag (nmin_mag[a]),
      .den_mag (d_mag[a]),
      .neg_in  (neg_min[a]),
      .quot    (q_min[a]),
      .neg_out (n_min[a])
    );
    rbsi_div #(.CW(CW), .FB(FRAC_BITS)) u_div_max (
      .clk     (clk),
      .en      (en),
      .num_mag (nmax_mag[a]),
      .den_mag (d_mag[a]),
      .neg_in  (neg_max[a]),
      .quot    (q_max[a]),
      .neg_out (n_max[a])
    );
  end

  // Valid bits and axis flags keep pace with the divider stages.
  logic                 vq   [1:NW];
  rbsi_pkg::rbsi_side_t sq   [1:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NW; i++) begin
        vq[i] <= 1'b0;
      end
    end else if (en) begin
      vq[1] <= v0;
      for (int i = 2; i <= NW; i++) begin
        vq[i] <= vq[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[1] <= side0;
      for (int i = 2; i <= NW; i++) begin
        sq[i] <= sq[i-1];
      end
    end
  end

  rbsi_isect #(.CW(CW), .FB(FRAC_BITS)) u_isect (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vq[NW]),
    .q_min     (q_min),
    .n_min     (n_min),
    .q_max     (q_max),
    .n_max     (n_max),
    .side      (sq[NW]),
    .out_valid (out_valid),
    .hit       (hit),
    .distance  (distance)
  );

endmodule
`default_nettype wire
